>>> design/swrr_pkg.sv
// shared types and codes for the sliding window reorder receiver
// no dependencies; imported by every other design file
package swrr_pkg;

	localparam int TAG_W = 16;
	localparam int SEQ_W = 32;
	localparam int WIN_REG_W = 6;

	localparam logic [1:0] PKT_START = 2'd0;
	localparam logic [1:0] PKT_DATA  = 2'd1;
	localparam logic [1:0] PKT_END   = 2'd2;

	localparam logic [1:0] RES_DELIVER  = 2'd0;
	localparam logic [1:0] RES_ACK      = 2'd1;
	localparam logic [1:0] RES_FINISHED = 2'd2;
	localparam logic [1:0] RES_ABORTED  = 2'd3;

	localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 6'd32;

	typedef struct packed {
		logic [1:0]       packet_kind;
		logic [SEQ_W-1:0] sequence_number;
		logic             checksum_good;
		logic [TAG_W-1:0] payload_tag;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       result_kind;
		logic [SEQ_W-1:0] ack_number;
		logic [TAG_W-1:0] delivered_tag;
		logic             last_of_run;
	} out_item_t;

	// per-cell command from the sequencer
	typedef struct packed {
		logic shift;
		logic write;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DELIVER,
		ST_FINISH
	} state_t;

endpackage

>>> design/swrr_cell.sv
// one slot of the receive window: a received mark and the held payload tag
// depends on swrr_pkg; instantiated in a row by the top level
module swrr_cell
	import swrr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [TAG_W-1:0] tag_wr,
	input  logic             next_received,
	input  logic [TAG_W-1:0] next_tag,
	output logic             received,
	output logic [TAG_W-1:0] tag
);

	logic             received_q;
	logic [TAG_W-1:0] tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			received_q <= 1'b0;
		end else if (ctl.shift) begin
			received_q <= next_received;
		end else if (ctl.write) begin
			received_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			tag_q <= next_tag;
		end else if (ctl.write) begin
			tag_q <= tag_wr;
		end
	end

	assign received = received_q;
	assign tag      = tag_q;

endmodule

>>> design/sliding_window_reorder_receiver.sv
// Selective-repeat receive window with in-order release of payload tags.
// Input channel item/item_valid/item_stall: one packet header event per transfer.
// Result channel result/result_valid/result_stall: deliver, ack, finished or aborted.
// Config channel cfg_valid/cfg_ready/cfg_data writes the receive window size
// (clamped to 1..MAX_WINDOW); cfg_ready is always high.
// Each slot of the window is a cell in a row; a release moves the whole row
// down one slot per cycle while the output register can load, and cell 0 supplies the tag being delivered.
// Flow: an item is registered from ST_IDLE and decided in ST_EVAL once the
// output register can load; an in-order packet then releases its run of
// held slots from ST_DELIVER, one deliver result per tag, closed by an ack;
// a good END gives an ack and then a finished result from ST_FINISH.
// item_stall is high from the transfer until the last result is loaded into
// the output register, which holds one result while result_stall is high;
// the sequencer waits on it, so no result is lost under stall.
// Reset clears the session flags, expected number and all received marks, and
// sets the window to 32; no clearing pass is needed.
module sliding_window_reorder_receiver
	import swrr_pkg::*;
#(
	parameter int MAX_WINDOW = 32
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  in_item_t             item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output out_item_t            result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [WIN_REG_W-1:0] cfg_data
);

	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);

	state_t                 state_q, state_d;
	in_item_t               item_q;
	logic                   started_q, closed_q;
	logic [SEQ_W-1:0]       expected_q;
	logic [WIN_REG_W-1:0]   window_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   result_valid_q;
	out_item_t              result_q;

	logic [MAX_WINDOW-1:0]  cell_received;
	logic [TAG_W-1:0]       cell_tag [MAX_WINDOW];
	cell_ctl_t              cell_ctl [MAX_WINDOW];

	logic [CNT_W-1:0]       win_eff;
	logic [SEQ_W-1:0]       seq_gap;
	logic [IDX_W-1:0]       gap_idx;
	logic                   below, in_win, can_load, run_more;
	logic                   eval_in_order, eval_end_good;
	logic                   emit, mark, shift, set_started, set_closed;
	out_item_t              emit_item;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (window_q == '0) begin
			win_eff = CNT_W'(1);
		end else if (32'(window_q) > 32'(MAX_WINDOW)) begin
			win_eff = CNT_W'(MAX_WINDOW);
		end else begin
			win_eff = CNT_W'(window_q);
		end
	end

	assign seq_gap  = item_q.sequence_number - expected_q;
	assign gap_idx  = seq_gap[IDX_W-1:0];
	assign below    = item_q.sequence_number < expected_q;
	assign in_win   = seq_gap < 32'(win_eff);
	assign can_load = !result_valid_q || !result_stall;
	assign run_more = cell_received[0] && (cnt_q < win_eff);

	assign eval_in_order = started_q && !closed_q && item_q.packet_kind != PKT_END
		&& item_q.checksum_good && !below && seq_gap == '0;
	assign eval_end_good = started_q && !closed_q && item_q.packet_kind == PKT_END
		&& item_q.checksum_good;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (can_load) begin
					if (eval_in_order)      state_d = ST_DELIVER;
					else if (eval_end_good) state_d = ST_FINISH;
					else                    state_d = ST_IDLE;
				end
			end
			ST_DELIVER: begin
				if (can_load && !run_more) state_d = ST_IDLE;
			end
			ST_FINISH: begin
				if (can_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// actions and result for this cycle
	always_comb begin
		emit        = 1'b0;
		mark        = 1'b0;
		shift       = 1'b0;
		set_started = 1'b0;
		set_closed  = 1'b0;
		emit_item   = '0;
		case (state_q)
			ST_EVAL: begin
				if (can_load && !closed_q) begin
					if (!started_q) begin
						emit                  = 1'b1;
						emit_item.last_of_run = 1'b1;
						if (item_q.packet_kind != PKT_START || !item_q.checksum_good) begin
							set_closed            = 1'b1;
							emit_item.result_kind = RES_ABORTED;
						end else begin
							set_started           = 1'b1;
							emit_item.result_kind = RES_ACK;
							emit_item.ack_number  = item_q.sequence_number;
						end
					end else if (item_q.packet_kind == PKT_END) begin
						set_closed = 1'b1;
						emit       = 1'b1;
						if (item_q.checksum_good) begin
							emit_item.result_kind = RES_ACK;
							emit_item.ack_number  = item_q.sequence_number;
						end else begin
							emit_item.result_kind = RES_FINISHED;
							emit_item.last_of_run = 1'b1;
						end
					end else if (item_q.checksum_good && !below && in_win) begin
						if (seq_gap == '0) begin
							mark = 1'b1;
						end else if (!cell_received[gap_idx]) begin
							mark                  = 1'b1;
							emit                  = 1'b1;
							emit_item.result_kind = RES_ACK;
							emit_item.ack_number  = expected_q;
							emit_item.last_of_run = 1'b1;
						end
					end
				end
			end
			ST_DELIVER: begin
				if (can_load) begin
					emit = 1'b1;
					if (run_more) begin
						shift                   = 1'b1;
						emit_item.result_kind   = RES_DELIVER;
						emit_item.delivered_tag = cell_tag[0];
					end else begin
						emit_item.result_kind = RES_ACK;
						emit_item.ack_number  = expected_q;
						emit_item.last_of_run = 1'b1;
					end
				end
			end
			ST_FINISH: begin
				if (can_load) begin
					emit                  = 1'b1;
					emit_item.result_kind = RES_FINISHED;
					emit_item.last_of_run = 1'b1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			started_q      <= 1'b0;
			closed_q       <= 1'b0;
			expected_q     <= '0;
			window_q       <= WINDOW_RESET;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (set_started) started_q <= 1'b1;
			if (set_closed)  closed_q  <= 1'b1;
			if (cfg_valid)   window_q  <= cfg_data;
			if (state_q == ST_EVAL) begin
				cnt_q <= '0;
			end else if (shift) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (shift) expected_q <= expected_q + SEQ_W'(1);
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) item_q <= item;
		if (emit) result_q <= emit_item;
	end

	// row of slot cells, shifting toward cell 0 on release
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic             nxt_received;
		logic [TAG_W-1:0] nxt_tag;

		if (i == MAX_WINDOW - 1) begin : g_top
			assign nxt_received = 1'b0;
			assign nxt_tag      = '0;
		end else begin : g_mid
			assign nxt_received = cell_received[i+1];
			assign nxt_tag      = cell_tag[i+1];
		end

		assign cell_ctl[i].shift = shift;
		assign cell_ctl[i].write = mark && (gap_idx == IDX_W'(i));

		swrr_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctl           (cell_ctl[i]),
			.tag_wr        (item_q.payload_tag),
			.next_received (nxt_received),
			.next_tag      (nxt_tag),
			.received      (cell_received[i]),
			.tag           (cell_tag[i])
		);
	end

	assign item_stall   = state_q != ST_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> design/swrr_checker.sv
// port-level checks for the sliding window reorder receiver
// depends on swrr_pkg; bound to the top level at the end of this file
module swrr_checker
	import swrr_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	// a held result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// one item at a time: busy right after an input transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input taken while previous item in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.result_kind == RES_ABORTED
			|| result.result_kind == RES_FINISHED) |-> result.last_of_run)
		else $error("session end result not last of run");

	// a deliver is never last of run: a release always closes with an ack
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind == RES_DELIVER |-> !result.last_of_run)
		else $error("deliver marked last of run");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind != RES_ACK |-> result.ack_number == '0)
		else $error("non-ack result carries ack number");

endmodule

bind sliding_window_reorder_receiver swrr_checker u_swrr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> tb/sv/swrr_checker.sv
`timescale 1ns / 1ps
// result checker for the sliding window reorder receiver: mirrors the receive
// window, predicts the results of each packet transfer and compares them in order; uses swrr_pkg
module swrr_tb_checker
	import swrr_pkg::*;
#(
	parameter int MAX_WINDOW = 32
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_stall,
	input  in_item_t             item,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  out_item_t            result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [WIN_REG_W-1:0] cfg_data,
	input  logic                 end_check,
	output int                   pending,
	output int                   fail_count,
	output int                   checked_count,
	output int                   longest_run
);

	logic [WIN_REG_W-1:0] window_reg;
	logic                 started;
	logic                 closed;
	logic [SEQ_W-1:0]     next_seq;
	logic                 slot_mark [MAX_WINDOW];
	logic [TAG_W-1:0]     slot_tag [MAX_WINDOW];
	out_item_t            awaited_results [$];
	out_item_t            head;
	logic                 end_seen;

	task automatic report_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic push_result(input logic [1:0] kind, input logic [SEQ_W-1:0] ackn,
			input logic [TAG_W-1:0] tag, input logic last);
		out_item_t r;
		r.result_kind   = kind;
		r.ack_number    = ackn;
		r.delivered_tag = tag;
		r.last_of_run   = last;
		awaited_results.push_back(r);
	endtask

	task automatic predict_packet(input in_item_t pkt);
		int unsigned      win;
		int unsigned      run;
		int unsigned      i;
		logic [SEQ_W-1:0] seq_gap;
		if (closed)
			return;
		// the session has to open with a good start packet
		if (!started) begin
			if (pkt.packet_kind != PKT_START || !pkt.checksum_good) begin
				closed = 1'b1;
				push_result(RES_ABORTED, '0, '0, 1'b1);
			end else begin
				started = 1'b1;
				push_result(RES_ACK, pkt.sequence_number, '0, 1'b1);
			end
			return;
		end
		if (pkt.packet_kind == PKT_END) begin
			closed = 1'b1;
			if (pkt.checksum_good)
				push_result(RES_ACK, pkt.sequence_number, '0, 1'b0);
			push_result(RES_FINISHED, '0, '0, 1'b1);
			return;
		end
		if (!pkt.checksum_good || pkt.sequence_number < next_seq)
			return;
		win = 32'(window_reg);
		if (win < 1)
			win = 1;
		if (win > MAX_WINDOW)
			win = MAX_WINDOW;
		seq_gap = pkt.sequence_number - next_seq;
		if (seq_gap >= win)
			return;
		// out of order: hold the tag, ack what is still missing
		if (seq_gap != 0) begin
			if (slot_mark[seq_gap])
				return;
			slot_mark[seq_gap] = 1'b1;
			slot_tag[seq_gap]  = pkt.payload_tag;
			push_result(RES_ACK, next_seq, '0, 1'b1);
			return;
		end
		slot_mark[0] = 1'b1;
		slot_tag[0]  = pkt.payload_tag;
		run = 0;
		while (run < win && slot_mark[run])
			run++;
		for (i = 0; i < run; i++)
			push_result(RES_DELIVER, '0, slot_tag[i], 1'b0);
		for (i = 0; i < MAX_WINDOW; i++) begin
			if (i + run < MAX_WINDOW) begin
				slot_mark[i] = slot_mark[i + run];
				slot_tag[i]  = slot_tag[i + run];
			end else begin
				slot_mark[i] = 1'b0;
				slot_tag[i]  = '0;
			end
		end
		next_seq = next_seq + run;
		push_result(RES_ACK, next_seq, '0, 1'b1);
		if (run > longest_run)
			longest_run = run;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_reg = WINDOW_RESET;
			started    = 1'b0;
			closed     = 1'b0;
			next_seq   = '0;
			for (int i = 0; i < MAX_WINDOW; i++) begin
				slot_mark[i] = 1'b0;
				slot_tag[i]  = '0;
			end
			awaited_results.delete();
			end_seen      = 1'b0;
			pending       = 0;
			fail_count    = 0;
			checked_count = 0;
			longest_run   = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				window_reg = cfg_data;
			if (item_valid && !item_stall)
				predict_packet(item);
			if (result_valid && !result_stall) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d/%0h/%0h/%0b",
						result.result_kind, result.ack_number, result.delivered_tag,
						result.last_of_run));
				end else begin
					head = awaited_results.pop_front();
					checked_count++;
					if (result.result_kind !== head.result_kind
							|| result.ack_number !== head.ack_number
							|| result.delivered_tag !== head.delivered_tag
							|| result.last_of_run !== head.last_of_run)
						report_mismatch($sformatf(
							"got %0d/%0h/%0h/%0b want %0d/%0h/%0h/%0b",
							result.result_kind, result.ack_number, result.delivered_tag,
							result.last_of_run, head.result_kind, head.ack_number,
							head.delivered_tag, head.last_of_run));
				end
			end
			if (end_check && !end_seen) begin
				end_seen = 1'b1;
				if (awaited_results.size() != 0)
					report_mismatch($sformatf("%0d expected results never arrived",
						awaited_results.size()));
			end
			pending = awaited_results.size();
		end
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the sliding window reorder receiver: clock, reset, window
// settings and packet stimulus; needs swrr_pkg, the receiver and swrr_tb_checker
module tb_top;
	import swrr_pkg::*;

	localparam int MAX_WINDOW   = 32;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 60;
	localparam int DRAIN_CYCLES = 2 * MAX_WINDOW + 8;
	localparam int CYCLE_LIMIT  = 800000;
	// the unused kind code, handled as data once the session is open
	localparam logic [1:0] PKT_SPARE = 2'd3;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_stall;
	in_item_t             item         = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	out_item_t            result;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [WIN_REG_W-1:0] cfg_data     = '0;
	logic                 end_check    = 1'b0;

	int               pending;
	int               fail_count;
	int               checked_count;
	int               longest_run;
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;
	int               sent_count    = 0;
	int               cycle_count   = 0;
	logic [SEQ_W-1:0] base_seq;

	sliding_window_reorder_receiver #(.MAX_WINDOW(MAX_WINDOW)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	swrr_tb_checker #(.MAX_WINDOW(MAX_WINDOW)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.end_check     (end_check),
		.pending       (pending),
		.fail_count    (fail_count),
		.checked_count (checked_count),
		.longest_run   (longest_run)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", CYCLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic in_item_t make_pkt(input logic [1:0] kind, input logic [SEQ_W-1:0] sn,
			input logic good, input logic [TAG_W-1:0] tag);
		in_item_t p;
		p.packet_kind     = kind;
		p.sequence_number = sn;
		p.checksum_good   = good;
		p.payload_tag     = tag;
		return p;
	endfunction

	// mostly data, with start and the spare code mixed in
	function automatic logic [1:0] data_kind();
		int unsigned roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return PKT_START;
		if (roll == 1)
			return PKT_SPARE;
		return PKT_DATA;
	endfunction

	function automatic logic [TAG_W-1:0] rand_tag();
		return TAG_W'($urandom);
	endfunction

	task automatic send_packet(input in_item_t pkt);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= pkt;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sent_count++;
	endtask

	// quiet the input and wait out every result plus a margin
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		int unsigned          phase;
		int unsigned          win_eff;
		int unsigned          blk;
		int unsigned          roll;
		int unsigned          j;
		int unsigned          k;
		int unsigned          off;
		int unsigned          phase_items;
		int unsigned          offsets [$];
		logic [WIN_REG_W-1:0] win_setting;
		logic [SEQ_W-1:0]     sn;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0)
				settle();
			if (phase < 2) begin
				send_idle_pct = 36;
				recv_idle_pct = 57;
			end else if (phase < 4) begin
				send_idle_pct = 57;
				recv_idle_pct = 36;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (phase)
				0, 5: begin
					win_setting = 6'd32;
				end
				1: begin
					win_setting = 6'd1;
				end
				2: begin
					win_setting = 6'd0;
				end
				3: begin
					win_setting = 6'd63;
				end
				default: begin
					win_setting = WIN_REG_W'($urandom_range(31, 2));
				end
			endcase
			win_eff = (win_setting == 0) ? 1
				: ((win_setting > MAX_WINDOW) ? MAX_WINDOW : 32'(win_setting));

			@(negedge clk);
			cfg_data  <= win_setting;
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			@(negedge clk);
			cfg_valid <= 1'b0;

			if (phase == 0) begin
				// start number is acked but the expected number stays at zero
				send_packet(make_pkt(PKT_START, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
				send_packet(make_pkt(PKT_DATA, 32'd0, 1'b1, 16'h0000));
				send_packet(make_pkt(PKT_DATA, 32'd1, 1'b0, 16'h1234));
				send_packet(make_pkt(PKT_DATA, 32'd0, 1'b1, 16'h5555));
				send_packet(make_pkt(PKT_DATA, 32'hFFFF_FFFF, 1'b1, 16'h7777));
				send_packet(make_pkt(PKT_DATA, 32'd33, 1'b1, 16'h3333));
				// top slot of the window, then the same slot again
				send_packet(make_pkt(PKT_DATA, 32'd32, 1'b1, 16'hFFFF));
				send_packet(make_pkt(PKT_DATA, 32'd32, 1'b1, 16'h0000));
				send_packet(make_pkt(PKT_START, 32'd3, 1'b1, 16'h0003));
				send_packet(make_pkt(PKT_SPARE, 32'd2, 1'b1, 16'hAAAA));
				// releases the held run 1..3
				send_packet(make_pkt(PKT_DATA, 32'd1, 1'b1, 16'h0001));
				send_packet(make_pkt(PKT_SPARE, 32'd4, 1'b0, 16'h4444));
				send_packet(make_pkt(PKT_START, 32'd4, 1'b0, 16'h8888));
				base_seq = 32'd4;
			end

			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				// one block of a sender window, in shuffled or reversed order
				blk = $urandom_range(win_eff, 1);
				offsets.delete();
				if ($urandom_range(3) == 0) begin
					for (j = 0; j < blk; j++)
						offsets.push_front(j);
				end else begin
					for (j = 0; j < blk; j++)
						offsets.push_back(j);
					for (j = blk - 1; j > 0; j--) begin
						k = $urandom_range(j);
						off = offsets[j];
						offsets[j] = offsets[k];
						offsets[k] = off;
					end
				end
				while (offsets.size() > 0) begin
					roll = $urandom_range(99);
					if (roll < 10) begin
						send_packet(make_pkt(data_kind(), $urandom, 1'($urandom_range(1)),
							rand_tag()));
					end else if (roll < 16) begin
						// duplicates around the window base
						sn = base_seq + $urandom_range(blk) - 2;
						send_packet(make_pkt(data_kind(), sn, 1'b1, rand_tag()));
					end else if (roll < 20) begin
						sn = base_seq + win_eff + $urandom_range(7);
						send_packet(make_pkt(data_kind(), sn, 1'b1, rand_tag()));
					end else begin
						off = offsets.pop_front();
						sn  = base_seq + off;
						if ($urandom_range(99) < 12) begin
							// corrupted copy, resent later in the block
							send_packet(make_pkt(data_kind(), sn, 1'b0, rand_tag()));
							offsets.push_back(off);
						end else begin
							send_packet(make_pkt(data_kind(), sn, 1'b1, rand_tag()));
						end
						phase_items++;
					end
				end
				base_seq = base_seq + blk;
			end
		end

		// close the session, then show that a closed session ignores everything
		send_packet(make_pkt(PKT_END, base_seq, 1'($urandom_range(1)), rand_tag()));
		send_packet(make_pkt(PKT_START, 32'd0, 1'b1, 16'h0F0F));
		send_packet(make_pkt(PKT_DATA, base_seq, 1'b1, 16'hF0F0));
		send_packet(make_pkt(PKT_END, base_seq, 1'b1, 16'h00FF));
		settle();
		end_check <= 1'b1;
		repeat (2) @(negedge clk);

		$display("%0d packet events over %0d window settings and three idle mixes",
			sent_count, PHASES);
		$display("%0d results checked, longest in-order release %0d tags",
			checked_count, longest_run);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
design/swrr_pkg.sv
design/swrr_cell.sv
design/sliding_window_reorder_receiver.sv
design/swrr_checker.sv
tb/sv/swrr_checker.sv
tb/sv/tb_top.sv
